>>> rtl/core/hfcc_pkg.sv
// shared types, constants and the crc-8 byte step for the humidity frame check and convert unit
package hfcc_pkg;

    // crc-8 as used by the sensor: poly 0x31, init 0xff, msb first, no final xor
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // fixed-point conversion constants, results in hundredths
    localparam logic [14:0] TEMP_GAIN   = 15'd17572;
    localparam logic [15:0] TEMP_OFFSET = 16'd4685;
    localparam logic [13:0] HUM_GAIN    = 14'd12500;
    localparam logic [13:0] HUM_OFFSET  = 14'd600;
    localparam logic [13:0] HUM_MAX     = 14'd10000;

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // frame status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_BAD = 2'd1,
        STATUS_HUM_BAD  = 2'd2
    } status_t;

    // input item: one received byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } hfcc_in_t;

    // result item
    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        status_t            frame_status;
    } hfcc_out_t;

    // checked frame handed from front to back
    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        status_t     status;
    } hfcc_job_t;

    // one byte through the crc, eight shift steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/humidity_frame_check_convert_unit.sv
// top level of the humidity frame check and convert unit
// Takes a six-byte measurement frame (temperature word, its crc, humidity word, its crc),
// one byte per item, and gives one result per frame: temperature in 0.01 degC, humidity in
// 0.01 %RH clamped to 0..10000, and a status naming the first failing crc (values zero then).
// A frame_start byte restarts the count; otherwise frames follow each other without marker.
// One byte is accepted every cycle while s_ready is high; the front runs the crc byte step and
// word assembly combinationally. The result of a frame is valid once it has passed the queue
// (written on the accepting edge of its sixth byte), the scaling multiply and the result register,
// and the queue lets the byte side keep going while results wait; s_ready drops only when
// QUEUE_DEPTH finished frames wait in the queue behind both stalled back stages.
module humidity_frame_check_convert_unit #(
    parameter int QUEUE_DEPTH = hfcc_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hfcc_pkg::hfcc_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hfcc_pkg::hfcc_out_t  m_data
);

    logic                accept;
    logic                push;
    hfcc_pkg::hfcc_job_t push_job;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    hfcc_pkg::hfcc_job_t q_job;

    // input handshake
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    hfcc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_item  (s_data),
        .push     (push),
        .push_job (push_job)
    );

    hfcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_job),
        .empty    (q_empty)
    );

    hfcc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/core/hfcc_front.sv
// front part: byte counting, crc checking and word assembly, one frame job per six bytes
module hfcc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  hfcc_pkg::hfcc_in_t   in_item,
    output logic                 push,
    output hfcc_pkg::hfcc_job_t  push_job
);

    // byte positions within the frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [7:0]  hum_hi_reg, hum_hi_next;
    logic [15:0] hum_word_reg, hum_word_next;
    logic        temp_fail_reg, temp_fail_next;

    logic [2:0]  eff_pos;
    logic [7:0]  crc_in;
    logic [7:0]  crc_step;
    logic [7:0]  b;

    // effective position: a frame start or an out-of-range count restarts at byte 0
    assign b       = in_item.data_byte;
    assign eff_pos = (in_item.frame_start || pos_reg > POS_H_CRC) ? POS_T_HI : pos_reg;

    // crc restarts at the first byte of each word
    assign crc_in   = (eff_pos == POS_T_HI || eff_pos == POS_H_HI) ? hfcc_pkg::CRC_INIT
                                                                   : crc_reg;
    assign crc_step = hfcc_pkg::crc8_byte(crc_in, b);

    // job goes out with the last byte
    assign push = accept && (eff_pos == POS_H_CRC);
    always_comb begin
        push_job.temp_word = temp_word_reg;
        push_job.hum_word  = hum_word_reg;
        if (temp_fail_reg) begin
            push_job.status = hfcc_pkg::STATUS_TEMP_BAD;
        end else if (crc_reg != b) begin
            push_job.status = hfcc_pkg::STATUS_HUM_BAD;
        end else begin
            push_job.status = hfcc_pkg::STATUS_OK;
        end
    end

    // per-position update of the frame state
    always_comb begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_hi_next    = hum_hi_reg;
        hum_word_next  = hum_word_reg;
        temp_fail_next = temp_fail_reg;
        if (accept) begin
            pos_next = (eff_pos == POS_H_CRC) ? POS_T_HI : eff_pos + 3'd1;
            unique case (eff_pos)
                POS_T_HI: begin
                    crc_next       = crc_step;
                    temp_word_next = {b, 8'd0};
                end
                POS_T_LO: begin
                    crc_next       = crc_step;
                    temp_word_next = {temp_word_reg[15:8], b};
                end
                POS_T_CRC: begin
                    temp_fail_next = (crc_reg != b);
                    crc_next       = hfcc_pkg::CRC_INIT;
                end
                POS_H_HI: begin
                    crc_next    = crc_step;
                    hum_hi_next = b;
                end
                POS_H_LO: begin
                    crc_next      = crc_step;
                    hum_word_next = {hum_hi_reg, b};
                end
                default: begin
                    crc_next = hfcc_pkg::CRC_INIT;
                end
            endcase
        end
    end

    // frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= hfcc_pkg::CRC_INIT;
            temp_word_reg <= '0;
            hum_hi_reg    <= '0;
            hum_word_reg  <= '0;
            temp_fail_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_word_reg <= temp_word_next;
            hum_hi_reg    <= hum_hi_next;
            hum_word_reg  <= hum_word_next;
            temp_fail_reg <= temp_fail_next;
        end
    end

endmodule

>>> rtl/core/hfcc_queue.sv
// short job queue between front and back
module hfcc_queue #(
    parameter int DEPTH = hfcc_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  hfcc_pkg::hfcc_job_t  push_job,
    output logic                 full,
    input  logic                 pop,
    output hfcc_pkg::hfcc_job_t  pop_job,
    output logic                 empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hfcc_pkg::hfcc_job_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // checks on queue use
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("job pushed into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop) else $error("job popped from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH)) else $error("queue count beyond depth");

endmodule

>>> rtl/core/hfcc_back.sv
// back part: scaling multiplies, offset and saturation, result register
module hfcc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  hfcc_pkg::hfcc_job_t  q_job,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hfcc_pkg::hfcc_out_t  m_data
);

    logic                s1_valid_reg, s1_valid_next;
    logic [30:0]         t_prod_reg;
    logic [29:0]         h_prod_reg;
    hfcc_pkg::status_t   s1_status_reg;
    logic                out_valid_reg, out_valid_next;
    hfcc_pkg::hfcc_out_t out_reg, out_next;

    logic                out_free;
    logic                s1_free;
    logic [14:0]         t_scaled;
    logic signed [15:0]  t_sum;
    logic [13:0]         h_scaled;
    logic [13:0]         h_sub;

    // stall chain from the result side back to the queue
    assign out_free = !out_valid_reg || m_ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign q_pop    = !q_empty && s1_free;

    // stage 1: scale both words
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            t_prod_reg    <= 31'(q_job.temp_word) * 31'(hfcc_pkg::TEMP_GAIN);
            h_prod_reg    <= 30'(q_job.hum_word) * 30'(hfcc_pkg::HUM_GAIN);
            s1_status_reg <= q_job.status;
        end
    end

    // stage 2: offsets, clamp and zeroing on crc error
    always_comb begin
        t_scaled = t_prod_reg[30:16];
        h_scaled = h_prod_reg[29:16];
        t_sum    = signed'({1'b0, t_scaled}) - signed'(hfcc_pkg::TEMP_OFFSET);
        h_sub    = h_scaled - hfcc_pkg::HUM_OFFSET;
        out_next = '0;
        out_next.frame_status = s1_status_reg;
        if (s1_status_reg == hfcc_pkg::STATUS_OK) begin
            out_next.temperature_centi = t_sum[14:0];
            if (h_scaled < hfcc_pkg::HUM_OFFSET) begin
                out_next.humidity_centi = '0;
            end else if (h_sub > hfcc_pkg::HUM_MAX) begin
                out_next.humidity_centi = hfcc_pkg::HUM_MAX;
            end else begin
                out_next.humidity_centi = h_sub;
            end
        end
    end

    // valid bits of both stages
    always_comb begin
        s1_valid_next  = s1_free ? q_pop : s1_valid_reg;
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_free && s1_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // values are cleared on any crc error
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_status != hfcc_pkg::STATUS_OK)
        |-> (m_data.temperature_centi == '0 && m_data.humidity_centi == '0))
        else $error("non-zero values on failed frame");
    // humidity stays within its clamp
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.humidity_centi <= hfcc_pkg::HUM_MAX)
        else $error("humidity beyond clamp");

endmodule

>>> tb/humidity_frame_check_convert_unit_test.sv
// testbench for the humidity frame check and convert unit: byte driver, result monitor, frame predictor
module humidity_frame_check_convert_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 10;
    localparam int ITEMS_PER_PHASE = 475;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    hfcc_pkg::hfcc_in_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    hfcc_pkg::hfcc_out_t m_data;

    // bytes waiting to be offered, readings waiting to come out
    hfcc_pkg::hfcc_in_t  byte_backlog[$];
    hfcc_pkg::hfcc_out_t expected_readings[$];

    bit s_took        = 1'b0;
    int cycle_count   = 0;
    int fail_count    = 0;
    int bytes_queued  = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    bit force_marker  = 1'b0;

    // predictor copy of the frame state
    logic [2:0]  pred_pos       = 3'd0;
    logic [7:0]  pred_crc       = hfcc_pkg::CRC_INIT;
    logic [15:0] pred_temp_word = 16'd0;
    logic [7:0]  pred_hum_high  = 8'd0;
    logic [15:0] pred_hum_word  = 16'd0;
    logic        pred_temp_fail = 1'b0;

    humidity_frame_check_convert_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // bit-serial crc-8, msb first
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            if (r[7] ^ b[i]) begin
                r = {r[6:0], 1'b0} ^ hfcc_pkg::CRC_POLY;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

    // advance the frame state by one byte, giving a reading after the sixth
    function automatic void absorb_byte(input hfcc_pkg::hfcc_in_t it, output bit produced,
                                        output hfcc_pkg::hfcc_out_t reading);
        logic [2:0]  pos;
        logic [7:0]  b;
        int unsigned scaled;
        int          t_val;
        int          h_val;
        bit          hum_fail;
        b        = it.data_byte;
        pos      = it.frame_start ? 3'd0 : pred_pos;
        produced = 1'b0;
        reading  = '0;
        if (pos > 3'd5) pos = 3'd0;
        case (pos)
            3'd0: begin
                pred_crc       = crc_fold(hfcc_pkg::CRC_INIT, b);
                pred_temp_word = {b, 8'h00};
            end
            3'd1: begin
                pred_crc            = crc_fold(pred_crc, b);
                pred_temp_word[7:0] = b;
            end
            3'd2: begin
                pred_temp_fail = (pred_crc != b);
                pred_crc       = hfcc_pkg::CRC_INIT;
            end
            3'd3: begin
                pred_crc      = crc_fold(hfcc_pkg::CRC_INIT, b);
                pred_hum_high = b;
            end
            3'd4: begin
                pred_crc      = crc_fold(pred_crc, b);
                pred_hum_word = {pred_hum_high, b};
            end
            default: begin
                hum_fail = (pred_crc != b);
                if (pred_temp_fail) begin
                    reading.frame_status = hfcc_pkg::STATUS_TEMP_BAD;
                end else if (hum_fail) begin
                    reading.frame_status = hfcc_pkg::STATUS_HUM_BAD;
                end else begin
                    scaled = 32'(hfcc_pkg::TEMP_GAIN) * {16'd0, pred_temp_word};
                    t_val  = int'(scaled >> 16) - int'(hfcc_pkg::TEMP_OFFSET);
                    scaled = 32'(hfcc_pkg::HUM_GAIN) * {16'd0, pred_hum_word};
                    h_val  = int'(scaled >> 16) - int'(hfcc_pkg::HUM_OFFSET);
                    if (h_val < 0) h_val = 0;
                    if (h_val > int'(hfcc_pkg::HUM_MAX)) h_val = int'(hfcc_pkg::HUM_MAX);
                    reading.temperature_centi = t_val[14:0];
                    reading.humidity_centi    = h_val[13:0];
                    reading.frame_status      = hfcc_pkg::STATUS_OK;
                end
                produced = 1'b1;
                pred_crc = hfcc_pkg::CRC_INIT;
            end
        endcase
        pred_pos = (pos >= 3'd5) ? 3'd0 : pos + 3'd1;
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic start);
        hfcc_pkg::hfcc_in_t it;
        it.data_byte   = b;
        it.frame_start = start;
        byte_backlog.push_back(it);
        bytes_queued++;
    endtask

    // one six-byte frame, with either crc optionally spoilt
    task automatic queue_frame(input logic [15:0] tw, input logic [15:0] hw,
                               input bit temp_bad, input bit hum_bad, input bit marker);
        logic [7:0] tc;
        logic [7:0] hc;
        tc = crc_fold(crc_fold(hfcc_pkg::CRC_INIT, tw[15:8]), tw[7:0]);
        hc = crc_fold(crc_fold(hfcc_pkg::CRC_INIT, hw[15:8]), hw[7:0]);
        if (temp_bad) tc = tc ^ 8'($urandom_range(255, 1));
        if (hum_bad) hc = hc ^ 8'($urandom_range(255, 1));
        add_byte(tw[15:8], marker);
        add_byte(tw[7:0], 1'b0);
        add_byte(tc, 1'b0);
        add_byte(hw[15:8], 1'b0);
        add_byte(hw[7:0], 1'b0);
        add_byte(hc, 1'b0);
    endtask

    // mostly good frames, some with bad crcs, some cut short, a little noise
    task automatic queue_random_stretch();
        int pick;
        int n;
        bit marker;
        pick         = $urandom_range(99);
        marker       = force_marker || ($urandom_range(1) == 1);
        force_marker = 1'b0;
        if (pick < 70) begin
            queue_frame(16'($urandom), 16'($urandom), 1'b0, 1'b0, marker);
        end else if (pick < 80) begin
            queue_frame(16'($urandom), 16'($urandom), 1'b1, 1'b0, marker);
        end else if (pick < 88) begin
            queue_frame(16'($urandom), 16'($urandom), 1'b0, 1'b1, marker);
        end else if (pick < 92) begin
            queue_frame(16'($urandom), 16'($urandom), 1'b1, 1'b1, marker);
        end else if (pick < 97) begin
            n = $urandom_range(5, 1);
            add_byte(8'($urandom), marker);
            repeat (n - 1) add_byte(8'($urandom), 1'b0);
            force_marker = 1'b1;
        end else begin
            n = $urandom_range(4, 1);
            repeat (n) add_byte(8'($urandom), 1'($urandom_range(1)));
            force_marker = 1'b1;
        end
    endtask

    // sender stops until every byte is taken and every reading has come out
    task automatic wait_drained();
        do @(negedge aclk);
        while (byte_backlog.size() != 0 || s_valid || expected_readings.size() != 0);
        @(posedge aclk);
    endtask

    // byte driver
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_took)) begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_data  <= byte_backlog.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with long hold-offs on request
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_served != hold_asked) begin
                hold_served <= hold_asked;
                hold_left   <= HOLD_CYCLES;
                m_ready     <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // monitor: predict on accepted bytes, check accepted readings
    always @(posedge aclk) begin
        bit                  produced;
        hfcc_pkg::hfcc_out_t reading;
        hfcc_pkg::hfcc_out_t want;
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            absorb_byte(s_data, produced, reading);
            if (produced) expected_readings.push_back(reading);
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected reading: temperature_centi %0d humidity_centi %0d status %0d",
                       m_data.temperature_centi, m_data.humidity_centi, m_data.frame_status);
                fail_count++;
            end else begin
                want = expected_readings.pop_front();
                if (m_data.temperature_centi !== want.temperature_centi) begin
                    $error("temperature_centi: expected %0d, actual %0d",
                           want.temperature_centi, m_data.temperature_centi);
                    fail_count++;
                end
                if (m_data.humidity_centi !== want.humidity_centi) begin
                    $error("humidity_centi: expected %0d, actual %0d",
                           want.humidity_centi, m_data.humidity_centi);
                    fail_count++;
                end
                if (m_data.frame_status !== want.frame_status) begin
                    $error("frame_status: expected %0d, actual %0d",
                           want.frame_status, m_data.frame_status);
                    fail_count++;
                end
            end
        end
    end

    // run time limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        int idle_pcts[4];
        int stall_pcts[4];
        int phase_start;
        bit paused;
        idle_pcts  = '{0, 54, 0, 30};
        stall_pcts = '{0, 0, 54, 30};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // coldest and driest words, then hottest and wettest back to back with no marker
        queue_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        queue_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        // partial frame dropped by a fresh marker, then both crcs bad
        add_byte(8'hA5, 1'b1);
        add_byte(8'h5A, 1'b0);
        queue_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b1);
        // humidity crc bad only
        queue_frame(16'($urandom), 16'($urandom), 1'b0, 1'b1, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_pcts[ph];
            recv_stall_pct  = stall_pcts[ph];
            if (stall_pcts[ph] > 0) hold_asked++;
            phase_start = bytes_queued;
            paused      = 1'b0;
            while (bytes_queued - phase_start < ITEMS_PER_PHASE) begin
                queue_random_stretch();
                if (!paused && bytes_queued - phase_start >= ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/hfcc_pkg.sv
rtl/core/hfcc_front.sv
rtl/core/hfcc_queue.sv
rtl/core/hfcc_back.sv
rtl/core/humidity_frame_check_convert_unit.sv
tb/humidity_frame_check_convert_unit_test.sv
